// ===== rtl/core/rsbh_pkg.sv =====
// Package for the segment versus box hit block.
// Holds transaction types, register indexes and pipeline constants; no dependencies.
`default_nettype none
package rsbh_pkg;

    localparam int QBITS    = 18;
    localparam int MBITS    = 17;
    localparam int REMBITS  = 48;
    localparam int PRODBITS = 50;
    localparam int PIPE_LAT = QBITS + 4;

    localparam logic [16:0] M_ONE = 17'h10000;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        NA_NONE = 2'd0,
        NA_X    = 2'd1,
        NA_Y    = 2'd2,
        NA_Z    = 2'd3
    } t_axis;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [1:0]         normal_axis;
        logic               normal_negative;
    } t_result;

    typedef struct packed {
        logic             in_box;
        logic [2:0]       ok;
        logic [2:0][16:0] m;
    } t_div_res;

endpackage
`default_nettype wire

// ===== rtl/core/rsbh_div.sv =====
// Face parameter unit for one axis: face select and a restoring divider, one bit per stage.
// Depends on rsbh_pkg.
`default_nettype none
module rsbh_div
    import rsbh_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_s,
    input  wire logic signed [31:0] i_d,
    input  wire logic signed [31:0] i_lo,
    input  wire logic signed [31:0] i_hi,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic [MBITS-1:0]        o_m
);

    logic               r_v   [QBITS+1];
    logic [REMBITS-1:0] r_rem [QBITS+1];
    logic [31:0]        r_dv  [QBITS+1];
    logic [QBITS-1:0]   r_q   [QBITS+1];
    logic               r_neg [QBITS+1];
    logic               r_ovf [QBITS+1];
    logic               r_dnz [QBITS+1];

    logic signed [31:0] w_face;
    logic signed [32:0] w_diff;
    logic [32:0]        w_absn;
    logic [32:0]        w_absd;

    always_comb begin
        w_face = (i_d > 0) ? i_lo : i_hi;
        w_diff = 33'(w_face) - 33'(i_s);
        w_absn = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
        w_absd = i_d[31] ? 33'(-33'(i_d)) : 33'(i_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= {w_absn[31:0], 16'h0};
        r_dv[0]  <= w_absd[31:0];
        r_q[0]   <= '0;
        r_neg[0] <= w_diff[32] ^ i_d[31];
        r_ovf[0] <= {3'b0, w_absn[31:2]} >= w_absd;
        r_dnz[0] <= i_d != 0;
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        localparam int B = QBITS - 1 - k;
        logic [PRODBITS-1:0] w_sh;
        logic                w_ge;
        assign w_sh = {{(PRODBITS-32){1'b0}}, r_dv[k]} << B;
        assign w_ge = {2'b0, r_rem[k]} >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rem[k+1]  <= w_ge ? r_rem[k] - w_sh[REMBITS-1:0] : r_rem[k];
            r_q[k+1]    <= w_ge ? (r_q[k] | (QBITS'(1) << B)) : r_q[k];
            r_dv[k+1]   <= r_dv[k];
            r_neg[k+1]  <= r_neg[k];
            r_ovf[k+1]  <= r_ovf[k];
            r_dnz[k+1]  <= r_dnz[k];
        end
    end

    assign o_valid = r_v[QBITS];
    assign o_m     = r_q[QBITS][MBITS-1:0];
    assign o_ok    = r_dnz[QBITS] && !r_ovf[QBITS]
                     && (r_q[QBITS] <= {1'b0, M_ONE})
                     && !(r_neg[QBITS] && (r_q[QBITS] != '0));

endmodule
`default_nettype wire

// ===== rtl/core/rsbh_point.sv =====
// Hit point stages: products, truncating scale with saturation, range checks and face priority.
// Depends on rsbh_pkg.
`default_nettype none
module rsbh_point
    import rsbh_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_item              i_item,
    input  wire t_div_res           i_div,
    input  wire logic signed [31:0] i_lo [3],
    input  wire logic signed [31:0] i_hi [3],
    output logic                    o_done,
    output t_result                 o_res
);

    logic signed [31:0] w_s [3];
    logic signed [31:0] w_d [3];

    logic                       r_va, r_vb;
    logic signed [PRODBITS-1:0] r_prod [3][3];
    logic signed [31:0]         r_sa [3];
    logic signed [31:0]         r_sb [3];
    logic [2:0]                 r_dpa, r_dpb, r_oka, r_okb;
    logic                       r_ina, r_inb;
    logic signed [31:0]         r_p [3][3];

    logic signed [33:0] w_tr  [3][3];
    logic signed [34:0] w_sum [3][3];
    logic signed [31:0] w_sat [3][3];
    logic [2:0]         w_hit;
    t_result            w_res;

    assign w_s[0] = i_item.start_x;
    assign w_s[1] = i_item.start_y;
    assign w_s[2] = i_item.start_z;
    assign w_d[0] = i_item.dir_x;
    assign w_d[1] = i_item.dir_y;
    assign w_d[2] = i_item.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_va   <= i_valid;
            r_vb   <= r_va;
            o_done <= r_vb;
        end
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[a][c] <= PRODBITS'(w_d[c])
                                * PRODBITS'($signed({1'b0, i_div.m[a]}));
                r_p[a][c]    <= w_sat[a][c];
            end
            r_sa[a]  <= w_s[a];
            r_sb[a]  <= r_sa[a];
            r_dpa[a] <= w_d[a] > 0;
        end
        r_oka <= i_div.ok;
        r_ina <= i_div.in_box;
        r_dpb <= r_dpa;
        r_okb <= r_oka;
        r_inb <= r_ina;
        o_res <= w_res;
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                w_tr[a][c]  = r_prod[a][c][PRODBITS-1]
                              ? 34'((r_prod[a][c] + PRODBITS'(65535)) >>> 16)
                              : 34'(r_prod[a][c] >>> 16);
                w_sum[a][c] = 35'(r_sa[c]) + 35'(w_tr[a][c]);
                if (w_sum[a][c] > 35'sd2147483647) begin
                    w_sat[a][c] = 32'sh7FFFFFFF;
                end else if (w_sum[a][c] < -35'sd2147483648) begin
                    w_sat[a][c] = 32'sh80000000;
                end else begin
                    w_sat[a][c] = w_sum[a][c][31:0];
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_hit[a] = r_okb[a];
            for (int c = 0; c < 3; c++) begin
                if (c != a && (r_p[a][c] < i_lo[c] || r_p[a][c] > i_hi[c])) begin
                    w_hit[a] = 1'b0;
                end
            end
        end
        w_res = '0;
        if (r_inb) begin
            w_res.hit     = 1'b1;
            w_res.point_x = r_sb[0];
            w_res.point_y = r_sb[1];
            w_res.point_z = r_sb[2];
        end else if (w_hit[0]) begin
            w_res = {1'b1, r_p[0][0], r_p[0][1], r_p[0][2], NA_X, r_dpb[0]};
        end else if (w_hit[1]) begin
            w_res = {1'b1, r_p[1][0], r_p[1][1], r_p[1][2], NA_Y, r_dpb[1]};
        end else if (w_hit[2]) begin
            w_res = {1'b1, r_p[2][0], r_p[2][1], r_p[2][2], NA_Z, r_dpb[2]};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ray_segment_box_hit.sv =====
// Top level of the segment versus axis-aligned box hit test.
// Depends on rsbh_pkg, rsbh_div and rsbh_point.
//
//   channel   handshake          payload
//   input     start, busy        i_item (t_item)
//   result    o_done             o_res (t_result)
//   config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// One transaction may enter every cycle; its result is strobed on o_done after the pipeline.
// It passes the three 18-step restoring dividers, one quotient bit per stage, then rsbh_point.
// busy is always low. Reset clears the valid bits and the box registers to zero.
`default_nettype none
module ray_segment_box_hit
    import rsbh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_item,
    output logic             o_done,
    output t_result          o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    t_item              r_dly [QBITS+1];
    logic               r_in  [QBITS+1];
    logic               w_acc;
    logic               w_inside;
    logic [2:0]         w_dv;
    t_div_res           w_div;
    logic signed [31:0] w_s [3];
    logic signed [31:0] w_d [3];

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    assign w_s[0] = i_item.start_x;
    assign w_s[1] = i_item.start_y;
    assign w_s[2] = i_item.start_z;
    assign w_d[0] = i_item.dir_x;
    assign w_d[1] = i_item.dir_y;
    assign w_d[2] = i_item.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_X: r_lo[0] <= i_cfg_data;
                REG_MIN_Y: r_lo[1] <= i_cfg_data;
                REG_MIN_Z: r_lo[2] <= i_cfg_data;
                REG_MAX_X: r_hi[0] <= i_cfg_data;
                REG_MAX_Y: r_hi[1] <= i_cfg_data;
                REG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_inside = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (!(w_s[a] > r_lo[a] && w_s[a] < r_hi[a])) begin
                w_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly[0] <= i_item;
        r_in[0]  <= w_inside;
        for (int k = 0; k < QBITS; k++) begin
            r_dly[k+1] <= r_dly[k];
            r_in[k+1]  <= r_in[k];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rsbh_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_acc),
            .i_s     (w_s[a]),
            .i_d     (w_d[a]),
            .i_lo    (r_lo[a]),
            .i_hi    (r_hi[a]),
            .o_valid (w_dv[a]),
            .o_ok    (w_div.ok[a]),
            .o_m     (w_div.m[a])
        );
    end

    assign w_div.in_box = r_in[QBITS];

    rsbh_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv[0]),
        .i_item  (r_dly[QBITS]),
        .i_div   (w_div),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##PIPE_LAT o_done)
        else $error("result strobe missing after accepted transaction");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.hit |-> o_res.point_x == 0 && o_res.point_y == 0
            && o_res.point_z == 0 && o_res.normal_axis == NA_NONE
            && !o_res.normal_negative)
        else $error("miss result carries nonzero fields");

    a_lanes_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv[0] == w_dv[1] && w_dv[1] == w_dv[2])
        else $error("divider lanes out of step");

endmodule
`default_nettype wire
